>>> sv/idbr_pkg.sv
// Shared types, codes and the answer table of the identification bus responder.
// No dependencies; every other file of the block imports this package.
package idbr_pkg;

    // Default sizing, handed down from the top level
    localparam int REQUEST_BYTES_DEF     = 4;
    localparam int PRESSES_FOR_RESET_DEF = 5;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Bus byte (bit-reversed) that opens a request
    localparam logic [7:0] OPEN_BYTE = 8'h74;

    // Bytes in one answer
    localparam int ANSWER_LEN = 8;

    // Bus phase of the responder
    typedef enum logic [1:0] {
        PH_RESTART = 2'd0,
        PH_WAIT    = 2'd1,
        PH_READ    = 2'd2,
        PH_JTAG    = 2'd3
    } t_phase;

    // Action to take on the next completed request
    typedef enum logic [1:0] {
        ACT_DEFAULT = 2'd0,
        ACT_RESET   = 2'd1,
        ACT_DFU1    = 2'd2,
        ACT_DFU2    = 2'd3
    } t_action;

    // Answer selection
    typedef enum logic [1:0] {
        ANS_SERIAL_JTAG = 2'd0,
        ANS_SERIAL      = 2'd1,
        ANS_RESET       = 2'd2,
        ANS_DFU         = 2'd3
    } t_answer;

    // Indication codes on the result side
    typedef enum logic [1:0] {
        IND_NONE      = 2'd0,
        IND_DFU_ARMED = 2'd1,
        IND_RST_ARMED = 2'd2,
        IND_DFU_SENT  = 2'd3
    } t_ind;

    // Result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_WAKE = 1'b1;

    // One job for the back end: a wake pulse or a full answer
    typedef struct packed {
        logic    wake;
        t_answer ans;
        t_ind    ind;
    } t_job;

    // Byte idx of answer sel, first byte in the top lane of the row
    function automatic logic [7:0] answer_byte(t_answer sel, logic [2:0] idx);
        logic [63:0] row;
        unique case (sel)
            ANS_SERIAL_JTAG: row = 64'h75a0_0000_0000_0040;
            ANS_SERIAL:      row = 64'h7520_0010_0000_0092;
            ANS_RESET:       row = 64'h75c0_0000_0000_0083;
            ANS_DFU:         row = 64'h7520_0002_0000_00ad;
            default:         row = '0;
        endcase
        return row[8 * (3'd7 - idx) +: 8];
    endfunction

endpackage

>>> sv/idbr_front.sv
// Front end: accepts bus bytes and button presses, tracks bus phase and
// pending action, and emits one job per item that produces results. Uses idbr_pkg.
module idbr_front
    import idbr_pkg::*;
#(
    parameter int REQUEST_BYTES     = REQUEST_BYTES_DEF,
    parameter int PRESSES_FOR_RESET = PRESSES_FOR_RESET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_command,
    input  logic [7:0] i_raw_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_default_mode,
    output logic       o_job_valid,
    output t_job       o_job
);

    t_phase     r_phase,   n_phase;
    logic [2:0] r_br,      n_br;
    t_action    r_action,  n_action;
    logic [2:0] r_pc,      n_pc;
    logic       r_default_mode;

    logic [7:0] byte_rev;
    logic       is_open;
    logic [2:0] pc_inc;
    logic       press_rst;
    logic [2:0] br_inc;
    logic       req_done;

    // Bit-reverse the line byte and decode shared conditions
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            byte_rev[i] = i_raw_byte[7 - i];
        end
        is_open   = (byte_rev == OPEN_BYTE);
        pc_inc    = r_pc + 3'd1;
        press_rst = (pc_inc >= 3'(PRESSES_FOR_RESET));
        br_inc    = r_br + 3'd1;
        req_done  = !((br_inc < 3'(REQUEST_BYTES)) && (br_inc != 3'd0));
    end

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_br     = r_br;
        n_action = r_action;
        n_pc     = r_pc;
        if (i_accept) begin
            if (i_command) begin
                n_pc     = press_rst ? 3'd0 : pc_inc;
                n_action = press_rst ? ACT_RESET : ACT_DFU1;
                n_phase  = PH_WAIT;
                n_br     = 3'd0;
            end else begin
                unique case (r_phase)
                    PH_RESTART, PH_WAIT: begin
                        n_phase = is_open ? PH_READ : PH_WAIT;
                        n_br    = is_open ? 3'd1 : 3'd0;
                    end
                    PH_READ: begin
                        if (!req_done) begin
                            n_br = br_inc;
                        end else begin
                            n_br    = 3'd0;
                            n_phase = PH_WAIT;
                            unique case (r_action)
                                ACT_DEFAULT: begin
                                    if (r_default_mode) begin
                                        n_phase = PH_JTAG;
                                    end
                                end
                                ACT_RESET: n_action = ACT_DEFAULT;
                                ACT_DFU1:  n_action = ACT_DFU2;
                                default:   n_action = ACT_DFU2;
                            endcase
                        end
                    end
                    default: begin
                        // JTAG held: hold everything until a press
                    end
                endcase
            end
        end
    end

    // Job output
    always_comb begin
        o_job_valid = 1'b0;
        o_job.wake  = KIND_WAKE;
        o_job.ans   = ANS_SERIAL;
        o_job.ind   = IND_NONE;
        if (i_accept) begin
            if (i_command) begin
                o_job_valid = 1'b1;
                o_job.ind   = press_rst ? IND_RST_ARMED : IND_DFU_ARMED;
            end else begin
                unique case (r_phase)
                    PH_RESTART: o_job_valid = 1'b1;
                    PH_READ: begin
                        o_job_valid = req_done;
                        o_job.wake  = 1'b0;
                        unique case (r_action)
                            ACT_DEFAULT: o_job.ans = r_default_mode ? ANS_SERIAL_JTAG
                                                                   : ANS_SERIAL;
                            ACT_RESET:   o_job.ans = ANS_RESET;
                            ACT_DFU1:    o_job.ans = ANS_RESET;
                            default: begin
                                o_job.ans = ANS_DFU;
                                o_job.ind = IND_DFU_SENT;
                            end
                        endcase
                    end
                    default: o_job_valid = 1'b0;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_RESTART;
            r_br           <= 3'd0;
            r_action       <= ACT_DFU1;
            r_pc           <= 3'd0;
            r_default_mode <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_br     <= n_br;
            r_action <= n_action;
            r_pc     <= n_pc;
            if (i_cfg_we) begin
                r_default_mode <= i_cfg_default_mode;
            end
        end
    end

endmodule

>>> sv/idbr_queue.sv
// Job queue between front and back end: a small register FIFO with
// first-word fall-through. Uses idbr_pkg for the job type and depth.
module idbr_queue
    import idbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    input  logic i_rd,
    output logic o_valid,
    output t_job o_job,
    output logic o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_wr, do_rd;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = do_wr ? PTR_W'((CNT_W + 1)'(r_wr_ptr) + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_rd ? PTR_W'((CNT_W + 1)'(r_rd_ptr) + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

>>> sv/idbr_back.sv
// Back end: takes jobs from the queue and plays out a wake pulse or the
// eight bytes of an answer into the output register. Uses idbr_pkg.
module idbr_back
    import idbr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_take,
    input  logic       i_pop,
    output logic       o_empty,
    output logic       o_kind,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic [1:0] o_indication
);

    logic       r_busy;
    t_job       r_job;
    logic [2:0] r_idx;
    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_data;
    logic       r_last;
    t_ind       r_ind;

    logic       out_free;
    logic       emit;
    logic       cur_last;

    assign out_free   = !r_out_valid || i_pop;
    assign emit       = r_busy && out_free;
    assign cur_last   = r_job.wake || (r_idx == 3'(ANSWER_LEN - 1));
    assign o_job_take = i_job_valid && (!r_busy || (emit && cur_last));

    // Job and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_job_take) begin
            r_busy <= 1'b1;
        end else if (emit && cur_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
            r_idx <= 3'd0;
        end else if (emit) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    // Output register: load on emit, drop on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= r_job.wake ? KIND_WAKE : KIND_BYTE;
            r_data <= r_job.wake ? 8'h00 : answer_byte(r_job.ans, r_idx);
            r_last <= cur_last;
            r_ind  <= r_job.ind;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_kind       = r_kind;
    assign o_data       = r_data;
    assign o_last       = r_last;
    assign o_indication = r_ind;

endmodule

>>> sv/id_bus_request_responder_core.sv
// Top level of the identification bus responder: front end, job queue and
// back end. Uses idbr_pkg, idbr_front, idbr_queue and idbr_back.
//
//  channel   handshake                  payload
//  input     push / full                i_command, i_raw_byte
//  result    empty / pop                o_kind, o_data, o_last, o_indication
//  config    i_cfg_valid / o_cfg_ready  i_cfg_default_mode
//
// One item is accepted per cycle while the four-entry job queue has room; an
// item is classified in the cycle it is accepted.
// The back end sends one result per cycle while its output register is free: a wake
// pulse is one result and an answer eight, so the answer playout sets the sustained result rate.
// Results appear from one output register, after the job queue and the back end's job register.
// Synchronous active-low reset; the block is ready in the cycle after it.
// A stalled result side backs up into the queue, and full rises when it fills.
module id_bus_request_responder_core
    import idbr_pkg::*;
#(
    parameter int REQUEST_BYTES     = REQUEST_BYTES_DEF,
    parameter int PRESSES_FOR_RESET = PRESSES_FOR_RESET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_command,
    input  logic [7:0] i_raw_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_kind,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic [1:0] o_indication,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_default_mode
);

    logic accept;
    logic job_valid;
    t_job job;
    logic q_valid;
    t_job q_job;
    logic q_take;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // Classify items
    idbr_front #(
        .REQUEST_BYTES     (REQUEST_BYTES),
        .PRESSES_FOR_RESET (PRESSES_FOR_RESET)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_command          (i_command),
        .i_raw_byte         (i_raw_byte),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_default_mode (i_cfg_default_mode),
        .o_job_valid        (job_valid),
        .o_job              (job)
    );

    // Buffer jobs
    idbr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_valid),
        .i_wr_job (job),
        .i_rd     (q_take),
        .o_valid  (q_valid),
        .o_job    (q_job),
        .o_full   (full)
    );

    // Play out results
    idbr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_job_take   (q_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_last       (o_last),
        .o_indication (o_indication)
    );

    // Output register is empty right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // A wake pulse carries zero data and ends its transaction group
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_WAKE) |-> (o_data == 8'h00 && o_last))
        else $error("malformed wake result");

    // The DFU-sent indication only rides on answer bytes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_indication == IND_DFU_SENT) |-> (o_kind == KIND_BYTE))
        else $error("DFU indication on wake result");

    // A job is never taken from an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |-> q_valid)
        else $error("job taken from empty queue");

endmodule

>>> dv/tb_id_bus_request_responder_core.sv
// Self-checking testbench for id_bus_request_responder_core: directed table, then random
// request traffic in phases that alternate the default mode. Uses idbr_pkg for codes and sizing.
module tb_id_bus_request_responder_core
    import idbr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Input commands
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // Open byte as it arrives in line bit order
    localparam logic [7:0] OPEN_RAW = 8'h2e;

    // Cycles to let in-flight work settle before a mode write or the end
    localparam int IDLE_GUARD = 16;
    localparam int END_GUARD  = 40;

    // Counted items per random phase
    localparam int PHASE_ITEMS = 74;

    // Answer rows, first byte leftmost
    localparam logic [0:3][0:7][7:0] REPLY = {
        8'h75, 8'ha0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40,
        8'h75, 8'h20, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h92,
        8'h75, 8'hc0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h83,
        8'h75, 8'h20, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'had
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        t_ind       ind;
    } t_resp;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_MODE = 1'b1
    } t_row_op;

    // One directed row; a mode row carries the mode in raw bit 0
    typedef struct packed {
        t_row_op    op;
        logic       cmd;
        logic [7:0] raw;
        logic       typed;
        logic       has_res;
        t_resp      resp;
    } t_row;

    localparam int N_ROWS = 26;
    localparam t_resp NO_RESP = '0;

    localparam t_row PLAN [N_ROWS] = '{
        '{ROW_MODE, CMD_BYTE,  8'h00, 1'b0, 1'b0, NO_RESP},
        // restart pending: wake first, then the byte opens a request
        '{ROW_ITEM, CMD_BYTE,  OPEN_RAW, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_NONE}},
        '{ROW_ITEM, CMD_BYTE,  8'hff, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h00, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h80, 1'b0, 1'b0, NO_RESP},
        // non-open byte while waiting is dropped
        '{ROW_ITEM, CMD_BYTE,  8'h00, 1'b1, 1'b0, NO_RESP},
        // four presses arm DFU, the fifth arms reset
        '{ROW_ITEM, CMD_PRESS, 8'hff, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_DFU_ARMED}},
        '{ROW_ITEM, CMD_PRESS, 8'h00, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_DFU_ARMED}},
        '{ROW_ITEM, CMD_PRESS, 8'h5a, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_DFU_ARMED}},
        '{ROW_ITEM, CMD_PRESS, 8'ha5, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_DFU_ARMED}},
        '{ROW_ITEM, CMD_PRESS, 8'hff, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_RST_ARMED}},
        // reset answer, then the default answer in serial mode
        '{ROW_ITEM, CMD_BYTE,  OPEN_RAW, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h01, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'hfe, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h7f, 1'b0, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  OPEN_RAW, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  OPEN_RAW, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h55, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'haa, 1'b0, 1'b0, NO_RESP},
        '{ROW_MODE, CMD_BYTE,  8'h01, 1'b0, 1'b0, NO_RESP},
        // JTAG answer, after which bytes are dropped until a press
        '{ROW_ITEM, CMD_BYTE,  OPEN_RAW, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h80, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'h01, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  8'hff, 1'b0, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_BYTE,  OPEN_RAW, 1'b1, 1'b0, NO_RESP},
        '{ROW_ITEM, CMD_PRESS, 8'h00, 1'b1, 1'b1, '{KIND_WAKE, 8'h00, 1'b1, IND_DFU_ARMED}}
    };

    logic       i_clk;
    logic       i_rst_n            = 1'b0;
    logic       push               = 1'b0;
    logic       i_command          = CMD_BYTE;
    logic [7:0] i_raw_byte         = 8'h00;
    logic       pop                = 1'b0;
    logic       i_cfg_valid        = 1'b0;
    logic       i_cfg_default_mode = 1'b0;
    logic       full;
    logic       empty;
    logic       o_kind;
    logic [7:0] o_data;
    logic       o_last;
    logic [1:0] o_indication;
    logic       o_cfg_ready;

    // Responder state as predicted
    t_phase     bus_ph    = PH_RESTART;
    logic [2:0] req_cnt   = 3'd0;
    t_action    armed     = ACT_DFU1;
    logic [2:0] press_cnt = 3'd0;
    logic       mode_q    = 1'b0;

    t_resp reply_q[$];
    int    n_err      = 0;
    int    push_burst = 0;
    int    pop_burst  = 0;

    id_bus_request_responder_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_command          (i_command),
        .i_raw_byte         (i_raw_byte),
        .empty              (empty),
        .pop                (pop),
        .o_kind             (o_kind),
        .o_data             (o_data),
        .o_last             (o_last),
        .o_indication       (o_indication),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_default_mode (i_cfg_default_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    task automatic report(input string what);
        n_err++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Idle cycles before the next transaction; occasional bursts without any
    function automatic int draw_gap(ref int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Advance the responder state for one item and collect the results it causes;
    // return whether the item did anything at all
    function automatic bit predict_responder(input logic cmd, input logic [7:0] raw,
                                             ref t_resp made[$]);
        logic [7:0] rx;
        t_answer    sel;
        t_ind       ind;
        bit         acted;
        for (int i = 0; i < 8; i++) begin
            rx[i] = raw[7 - i];
        end
        acted = 1'b0;
        ind   = IND_NONE;
        sel   = ANS_SERIAL;

        // press: arm an action and restart enumeration
        if (cmd == CMD_PRESS) begin
            press_cnt = press_cnt + 3'd1;
            if (press_cnt >= PRESSES_FOR_RESET_DEF) begin
                armed     = ACT_RESET;
                press_cnt = 3'd0;
                ind       = IND_RST_ARMED;
            end else begin
                armed = ACT_DFU1;
                ind   = IND_DFU_ARMED;
            end
            bus_ph  = PH_WAIT;
            req_cnt = 3'd0;
            made.push_back('{KIND_WAKE, 8'h00, 1'b1, ind});
            return 1'b1;
        end

        // restart pending: emit the wake, then treat the byte as waiting
        if (bus_ph == PH_RESTART) begin
            bus_ph  = PH_WAIT;
            req_cnt = 3'd0;
            acted   = 1'b1;
            made.push_back('{KIND_WAKE, 8'h00, 1'b1, IND_NONE});
        end

        if (bus_ph == PH_WAIT) begin
            if (rx == OPEN_BYTE) begin
                bus_ph  = PH_READ;
                req_cnt = 3'd1;
                acted   = 1'b1;
            end
            return acted;
        end

        if (bus_ph == PH_JTAG) begin
            return acted;
        end

        // reading a request: answer once it is complete
        req_cnt = req_cnt + 3'd1;
        if (req_cnt < REQUEST_BYTES_DEF && req_cnt != 3'd0) begin
            return 1'b1;
        end
        req_cnt = 3'd0;
        bus_ph  = PH_WAIT;
        case (armed)
            ACT_DEFAULT: begin
                if (mode_q) begin
                    sel    = ANS_SERIAL_JTAG;
                    bus_ph = PH_JTAG;
                end else begin
                    sel = ANS_SERIAL;
                end
            end
            ACT_RESET: begin
                sel   = ANS_RESET;
                armed = ACT_DEFAULT;
            end
            ACT_DFU1: begin
                sel   = ANS_RESET;
                armed = ACT_DFU2;
            end
            default: begin
                sel = ANS_DFU;
                ind = IND_DFU_SENT;
            end
        endcase
        for (int i = 0; i < ANSWER_LEN; i++) begin
            made.push_back('{KIND_BYTE, REPLY[sel][i], (i == ANSWER_LEN - 1), ind});
        end
        return 1'b1;
    endfunction

    // Offer one item and hold it until accepted; keep push high when no gap follows
    task automatic push_item(input logic cmd, input logic [7:0] raw, input logic typed,
                             input logic has_res, input t_resp resp, output bit acted);
        int    gap;
        t_resp made[$];
        gap = draw_gap(push_burst);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_command  <= cmd;
        i_raw_byte <= raw;
        do @(posedge i_clk); while (full !== 1'b0);
        acted = predict_responder(cmd, raw, made);
        if (typed) begin
            if (has_res) begin
                reply_q.push_back(resp);
            end
        end else begin
            foreach (made[k]) begin
                reply_q.push_back(made[k]);
            end
        end
    endtask

    // Write the default mode once the block has drained
    task automatic write_mode(input logic m);
        push <= 1'b0;
        do @(posedge i_clk); while (reply_q.size() != 0);
        repeat (IDLE_GUARD) @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_default_mode <= m;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        mode_q = m;
    endtask

    // Result side: pop at random and check each transaction against the oldest expectation
    initial begin : result_side
        int    gap;
        t_resp want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(pop_burst);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            if (reply_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d data %02h", o_kind, o_data));
            end else begin
                want = reply_q.pop_front();
                if (o_kind !== want.kind)
                    report($sformatf("kind got %0d want %0d", o_kind, want.kind));
                if (o_data !== want.data)
                    report($sformatf("data got %02h want %02h", o_data, want.data));
                if (o_last !== want.last)
                    report($sformatf("last got %0d want %0d", o_last, want.last));
                if (o_indication !== want.ind)
                    report($sformatf("indication got %0d want %0d", o_indication, want.ind));
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain
    initial begin : stimulus
        bit         acted;
        int         counted;
        int         pick;
        int         extra;
        logic [0:4] phase_modes;
        phase_modes = 5'b01010;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (PLAN[r]) begin
            if (PLAN[r].op == ROW_MODE) begin
                write_mode(PLAN[r].raw[0]);
            end else begin
                push_item(PLAN[r].cmd, PLAN[r].raw, PLAN[r].typed, PLAN[r].has_res,
                          PLAN[r].resp, acted);
            end
        end

        // random phases, one default mode each
        for (int p = 0; p < 5; p++) begin
            write_mode(phase_modes[p]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // well-formed request with random content
                    push_item(CMD_BYTE, OPEN_RAW, 1'b0, 1'b0, NO_RESP, acted);
                    counted += acted;
                    for (int i = 1; i < REQUEST_BYTES_DEF; i++) begin
                        push_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                                  NO_RESP, acted);
                        counted += acted;
                    end
                end else if (pick < 75) begin
                    push_item(CMD_PRESS, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                              NO_RESP, acted);
                    counted += acted;
                end else if (pick < 90) begin
                    push_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                              NO_RESP, acted);
                    counted += acted;
                end else begin
                    // request cut short by a press
                    push_item(CMD_BYTE, OPEN_RAW, 1'b0, 1'b0, NO_RESP, acted);
                    counted += acted;
                    extra = $urandom_range(0, REQUEST_BYTES_DEF - 2);
                    for (int i = 0; i < extra; i++) begin
                        push_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                                  NO_RESP, acted);
                        counted += acted;
                    end
                    push_item(CMD_PRESS, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                              NO_RESP, acted);
                    counted += acted;
                end
            end
        end

        // drain, then watch for stray results
        push <= 1'b0;
        do @(posedge i_clk); while (reply_q.size() != 0);
        repeat (END_GUARD) @(posedge i_clk);
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
